@@ rtl/skt_pkg.sv @@
// Package for the sorted key table: beat types and the action and status codes.
// Depends on nothing; the sorted key table top imports it, the RAM does not.
`default_nettype none

package skt_pkg;

   // Action codes carried in a request beat.
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;

   // Status codes carried in a response beat.
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STS_FULL      = 2'd2;
   localparam logic [1:0] STS_EMPTY     = 2'd3;

   // Request beat.
   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] key;
      logic [15:0]        position;
   } req_type;

   // Response beat.
   typedef struct packed {
      logic [1:0] status;
      logic [5:0] found_index;
      logic [6:0] entry_count;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/skt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used by the sorted key table for its key store.
`default_nettype none

module skt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/sorted_key_table_top.sv @@
// Sorted key table: signed keys kept in ascending order in one RAM.
// How long a response takes grows with the keys greater than the new one on insert, with
// the entries after the removed one on delete, and with the index of the first match (the
// whole count on a miss) on search; rejected or unused requests skip the walk.
// One item in work at a time; the next request is taken after the response is registered.
// Reset (synchronous) empties the table at once; the key RAM itself is not cleared.
`default_nettype none

module sorted_key_table_top #(
   parameter int CAPACITY = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire skt_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output skt_pkg::rsp_type     rsp_data
);

   import skt_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_INS  = 3'd1;
   localparam logic [2:0] ST_DEL  = 3'd2;
   localparam logic [2:0] ST_SRCH = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic signed [31:0] key_ff, key_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [CW-1:0]      left_ff, left_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      tag_ff, tag_in;
   logic [1:0]         status_ff, status_in;
   logic [AW-1:0]      index_ff, index_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic               rd_en;
   logic [31:0]        rd_data;
   logic               key_gt;
   logic               key_eq;
   logic [AW-1:0]      del_pos;

   // Key store.
   skt_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_keys (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Compare the entry just read against the operand key.
   assign key_gt = $signed(rd_data) > key_ff;
   assign key_eq = rd_data == key_ff;

   // Delete position clamped to the last stored entry.
   assign del_pos = (req_data.position >= 16'(count_ff)) ? AW'(count_ff - 1'b1)
                                                        : AW'(req_data.position);

   // Sequencer: one RAM read issued per cycle, each returned entry handled in the cycle after its read.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      pend_in      = 1'b0;
      tag_in       = tag_ff;
      status_in    = status_ff;
      index_in     = index_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = key_ff;
      rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in    = req_data.key;
               index_in  = '0;
               status_in = STS_OK;
               state_in  = ST_DONE;
               case (req_data.action)
                  ACT_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = STS_FULL;
                     end else begin
                        addr_in  = AW'(count_ff - 1'b1);
                        left_in  = count_ff;
                        state_in = ST_INS;
                     end
                  end
                  ACT_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = STS_EMPTY;
                     end else begin
                        addr_in  = del_pos + 1'b1;
                        left_in  = count_ff - 1'b1 - CW'(del_pos);
                        state_in = ST_DEL;
                     end
                  end
                  ACT_SEARCH: begin
                     status_in = STS_NOT_FOUND;
                     addr_in   = '0;
                     left_in   = count_ff;
                     state_in  = ST_SRCH;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // Walk down from the top, moving larger keys up by one place.
         ST_INS: begin
            if (pend_ff && !key_gt) begin
               wr_en    = 1'b1;
               wr_addr  = tag_ff + 1'b1;
               count_in = count_ff + 1'b1;
               state_in = ST_DONE;
            end else if (!pend_ff && left_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = '0;
               count_in = count_ff + 1'b1;
               state_in = ST_DONE;
            end else begin
               if (pend_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = tag_ff + 1'b1;
                  wr_data = rd_data;
               end
               if (left_ff != '0) begin
                  rd_en   = 1'b1;
                  pend_in = 1'b1;
                  tag_in  = addr_ff;
                  addr_in = addr_ff - 1'b1;
                  left_in = left_ff - 1'b1;
               end
            end
         end

         // Walk up from the removed place, moving each later key down by one.
         ST_DEL: begin
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = tag_ff - 1'b1;
               wr_data = rd_data;
            end
            if (left_ff == '0) begin
               count_in = count_ff - 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               tag_in  = addr_ff;
               addr_in = addr_ff + 1'b1;
               left_in = left_ff - 1'b1;
            end
         end

         // Walk up from the bottom until the first equal key or the end of the stored entries.
         ST_SRCH: begin
            if (pend_ff && key_eq) begin
               status_in = STS_OK;
               index_in  = tag_ff;
               state_in  = ST_DONE;
            end else if (left_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               tag_in  = addr_ff;
               addr_in = addr_ff + 1'b1;
               left_in = left_ff - 1'b1;
            end
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.status      = status_ff;
               rsp_data_in.found_index = 6'(index_ff);
               rsp_data_in.entry_count = 7'(count_ff);
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Operand and result registers.
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      addr_ff     <= addr_in;
      left_ff     <= left_in;
      tag_ff      <= tag_in;
      status_ff   <= status_in;
      index_ff    <= index_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The table never holds more keys than it has room for.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   // Only the insert and delete walks write the key store.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_INS || state_ff == ST_DEL))
      else $error("key store written outside a shifting walk");

   // Every entry read back lies inside the stored part of the table.
   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (CW'(tag_ff) < count_ff))
      else $error("read of an entry beyond the stored count");

   // A finished result reaches the output register on the next cycle when it is free.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("finished result not presented");

   // A taken request always moves the sequencer out of idle, so no other request is taken meanwhile.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("accepted request left the sequencer idle");

endmodule

`default_nettype wire
